// ----- hdl/acgl_pkg.sv -----
// Package for the clip, gain and low-pass audio core.
// Holds widths, register indexes, reset values, microcode types and the microcode ROM.
// No dependencies.
package acgl_pkg;

   localparam int SAMPLE_BITS    = 12;
   localparam int PCT_BITS       = 7;
   localparam int GAIN_BITS      = 8;
   localparam int ALPHA_BITS     = 16;
   localparam int CSR_DATA_BITS  = 16;
   localparam int CSR_INDEX_BITS = 2;
   localparam int STATE_BITS     = 16;
   localparam int MUL_BITS       = 21;
   localparam int PROD_BITS      = 2 * MUL_BITS;
   localparam int MAG_BITS       = 20;
   localparam int PC_BITS        = 4;

   // Reciprocal constants for exact floor division by 100 and by 50 of the
   // products that reach them (below 2^19 and 2^20).
   localparam logic [MUL_BITS-1:0] RECIP_100       = 21'd335545;
   localparam int                  RECIP_100_SHIFT = 25;
   localparam logic [MUL_BITS-1:0] RECIP_50        = 21'd1342178;
   localparam int                  RECIP_50_SHIFT  = 26;

   localparam logic [PCT_BITS-1:0]    PCT_FULL     = 7'd100;
   localparam logic [12:0]            CLIP_MARGIN  = 13'd20;

   localparam logic [PCT_BITS-1:0]    RESET_CLIP_PERCENT  = 7'd0;
   localparam logic [GAIN_BITS-1:0]   RESET_GAIN_SETTING  = 8'd50;
   localparam logic [ALPHA_BITS-1:0]  RESET_LOWPASS_ALPHA = 16'd48534;
   localparam logic [SAMPLE_BITS-1:0] RESET_GROUND_LEVEL  = 12'd400;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_CLIP_PERCENT  = 2'd0,
      CSR_GAIN_SETTING  = 2'd1,
      CSR_LOWPASS_ALPHA = 2'd2,
      CSR_GROUND_LEVEL  = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      OP_LOAD,
      OP_MUL,
      OP_CLAMP,
      OP_DIFF,
      OP_FINISH
   } op_type;

   typedef enum logic [1:0] {
      A_PCT,
      A_PROD,
      A_MAG
   } a_sel_type;

   typedef enum logic [2:0] {
      B_GND,
      B_RECIP100,
      B_GAIN,
      B_RECIP50,
      B_ALPHA
   } b_sel_type;

   typedef enum logic [1:0] {
      HOLD_NONE,
      HOLD_NO_REQ,
      HOLD_OUT_BUSY
   } hold_type;

   typedef struct packed {
      op_type              op;
      a_sel_type           a_sel;
      b_sel_type           b_sel;
      hold_type            hold;
      logic                jump;
      logic [PC_BITS-1:0]  target;
   } ucode_type;

   localparam logic [PC_BITS-1:0] PC_START  = 4'd0;
   localparam logic [PC_BITS-1:0] PC_FINISH = 4'd8;

   // The program: one control word per step. A hold stalls the step in place.
   function automatic ucode_type ucode_rom(input logic [PC_BITS-1:0] pc);
      ucode_type w;
      w = '{op: OP_LOAD, a_sel: A_PCT, b_sel: B_GND, hold: HOLD_NO_REQ,
            jump: 1'b1, target: PC_START};
      unique case (pc)
         4'd0: begin
            w = '{op: OP_LOAD, a_sel: A_PCT, b_sel: B_GND, hold: HOLD_NO_REQ,
                  jump: 1'b0, target: PC_START};
         end
         4'd1: begin
            w = '{op: OP_MUL, a_sel: A_PCT, b_sel: B_GND, hold: HOLD_NONE,
                  jump: 1'b0, target: PC_START};
         end
         4'd2: begin
            w = '{op: OP_MUL, a_sel: A_PROD, b_sel: B_RECIP100, hold: HOLD_NONE,
                  jump: 1'b0, target: PC_START};
         end
         4'd3: begin
            w = '{op: OP_CLAMP, a_sel: A_PCT, b_sel: B_GND, hold: HOLD_NONE,
                  jump: 1'b0, target: PC_START};
         end
         4'd4: begin
            w = '{op: OP_MUL, a_sel: A_MAG, b_sel: B_GAIN, hold: HOLD_NONE,
                  jump: 1'b0, target: PC_START};
         end
         4'd5: begin
            w = '{op: OP_MUL, a_sel: A_PROD, b_sel: B_RECIP50, hold: HOLD_NONE,
                  jump: 1'b0, target: PC_START};
         end
         4'd6: begin
            w = '{op: OP_DIFF, a_sel: A_PCT, b_sel: B_GND, hold: HOLD_NONE,
                  jump: 1'b0, target: PC_START};
         end
         4'd7: begin
            w = '{op: OP_MUL, a_sel: A_MAG, b_sel: B_ALPHA, hold: HOLD_NONE,
                  jump: 1'b0, target: PC_START};
         end
         4'd8: begin
            w = '{op: OP_FINISH, a_sel: A_PCT, b_sel: B_GND, hold: HOLD_OUT_BUSY,
                  jump: 1'b1, target: PC_START};
         end
         default: begin
            w = '{op: OP_LOAD, a_sel: A_PCT, b_sel: B_GND, hold: HOLD_NONE,
                  jump: 1'b1, target: PC_START};
         end
      endcase
      return w;
   endfunction

endpackage

// ----- hdl/audio_clip_gain_lowpass_core.sv -----
// Clip, gain and one-pole low-pass audio core, run by a microcoded sequencer.
// Depends on acgl_pkg (widths, register indexes, microcode ROM).
//
// The program has nine microcode steps, five of which share one 21x21
// multiplier; a new sample is taken only once the program is back at its
// load step, and the finishing step stalls while a result still waits.
// A finished result waits in the output register while the next sample is taken.
// Reset (synchronous, active high) restores the register defaults, clears the
// filter state and the output valid, and restarts the program at step 0.
module audio_clip_gain_lowpass_core (
   input  logic                                  clock,
   input  logic                                  reset,
   // Sample input channel
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [acgl_pkg::SAMPLE_BITS-1:0]      req_sample_in,
   // Result channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [acgl_pkg::SAMPLE_BITS-1:0]      rsp_sample_out,
   output logic                                  rsp_out_saturated,
   // Register write port
   input  logic                                  csr_we,
   input  logic [acgl_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [acgl_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);
   import acgl_pkg::*;

   // Configuration registers.
   logic [PCT_BITS-1:0]    clip_percent_ff,  clip_percent_in;
   logic [GAIN_BITS-1:0]   gain_setting_ff,  gain_setting_in;
   logic [ALPHA_BITS-1:0]  lowpass_alpha_ff, lowpass_alpha_in;
   logic [SAMPLE_BITS-1:0] ground_level_ff,  ground_level_in;

   // Sequencer and datapath registers.
   logic [PC_BITS-1:0]        pc_ff, pc_in;
   logic [PROD_BITS-1:0]      prod_ff, prod_in;
   logic [MAG_BITS-1:0]       mag_ff, mag_in;
   logic                      neg_ff, neg_in;
   logic [SAMPLE_BITS-1:0]    abs_dx_ff, abs_dx_in;
   logic signed [16:0]        past_ff, past_in;
   logic signed [STATE_BITS-1:0] prev_ff, prev_in;

   // Output register.
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_BITS-1:0]    sample_out_ff, sample_out_in;
   logic                      sat_ff, sat_in;

   ucode_type                 uword;
   logic                      out_busy;
   logic                      stall;
   logic                      finish;
   logic [PCT_BITS-1:0]       pct_eff;
   logic [PCT_BITS-1:0]       pct_rem;
   logic [MUL_BITS-1:0]       mul_a;
   logic [MUL_BITS-1:0]       mul_b;
   logic [PROD_BITS-1:0]      mul_p;

   // Step-local arithmetic.
   logic signed [SAMPLE_BITS:0] dx;
   logic [12:0]               half;
   logic [14:0]               gain_q;
   logic signed [16:0]        cur;
   logic signed [16:0]        diff;
   logic [15:0]               lp_mag;
   logic signed [16:0]        lp_term;
   logic signed [17:0]        y;

   // -------------------------------------------------------------------------
   // Configuration writes. An index outside the list is simply ignored; the
   // index width covers exactly the four registers.
   // -------------------------------------------------------------------------
   always_comb begin
      clip_percent_in  = clip_percent_ff;
      gain_setting_in  = gain_setting_ff;
      lowpass_alpha_in = lowpass_alpha_ff;
      ground_level_in  = ground_level_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_CLIP_PERCENT:  clip_percent_in  = csr_wdata[PCT_BITS-1:0];
            CSR_GAIN_SETTING:  gain_setting_in  = csr_wdata[GAIN_BITS-1:0];
            CSR_LOWPASS_ALPHA: lowpass_alpha_in = csr_wdata[ALPHA_BITS-1:0];
            CSR_GROUND_LEVEL:  ground_level_in  = csr_wdata[SAMPLE_BITS-1:0];
            default: ;
         endcase
      end
   end

   // -------------------------------------------------------------------------
   // Sequencer. The step counter indexes the microcode ROM; a word may hold
   // its step until a sample arrives or until the output register is free,
   // and the last word jumps back to the load step.
   // -------------------------------------------------------------------------
   assign uword    = ucode_rom(pc_ff);
   assign out_busy = rsp_valid_ff && !rsp_ready;

   always_comb begin
      stall = 1'b0;
      unique case (uword.hold)
         HOLD_NONE:     stall = 1'b0;
         HOLD_NO_REQ:   stall = !req_valid;
         HOLD_OUT_BUSY: stall = out_busy;
         default:       stall = 1'b0;
      endcase
      if (stall) begin
         pc_in = pc_ff;
      end else if (uword.jump) begin
         pc_in = uword.target;
      end else begin
         pc_in = pc_ff + 1'b1;
      end
   end

   assign req_ready = (uword.op == OP_LOAD);
   assign finish    = (uword.op == OP_FINISH) && !out_busy;

   // -------------------------------------------------------------------------
   // Shared multiplier with its operand selection. Every product lands in
   // prod_ff and is only used by a later step.
   // -------------------------------------------------------------------------
   // A percentage above 100 acts as 100, so the clip half-width stays >= 20.
   assign pct_eff = (clip_percent_ff > PCT_FULL) ? PCT_FULL : clip_percent_ff;
   assign pct_rem = PCT_FULL - pct_eff;

   always_comb begin
      unique case (uword.a_sel)
         A_PCT:   mul_a = {{(MUL_BITS-PCT_BITS){1'b0}}, pct_rem};
         A_PROD:  mul_a = prod_ff[MUL_BITS-1:0];
         A_MAG:   mul_a = {{(MUL_BITS-MAG_BITS){1'b0}}, mag_ff};
         default: mul_a = '0;
      endcase
      unique case (uword.b_sel)
         B_GND:      mul_b = {{(MUL_BITS-SAMPLE_BITS){1'b0}}, ground_level_ff};
         B_RECIP100: mul_b = RECIP_100;
         B_GAIN:     mul_b = {{(MUL_BITS-GAIN_BITS){1'b0}}, gain_setting_ff};
         B_RECIP50:  mul_b = RECIP_50;
         B_ALPHA:    mul_b = {{(MUL_BITS-ALPHA_BITS){1'b0}}, lowpass_alpha_ff};
         default:    mul_b = '0;
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // -------------------------------------------------------------------------
   // Datapath steps.
   //  Load:   distance from ground, its magnitude and sign; filter state
   //          relative to ground.
   //  Clamp:  half-width = floor((100-p)*ground/100) + 20; the clipped
   //          distance is the smaller of |distance| and the half-width.
   //  Diff:   gained value (sign applied, so the divide by 50 truncates toward
   //          zero) minus the past output, kept as magnitude and sign.
   //  Finish: y = previous + trunc0(alpha*diff / 2^16); saturate for the
   //          state (signed 16 bits) and for the output (0 to full scale).
   // -------------------------------------------------------------------------
   assign dx = $signed({1'b0, req_sample_in}) - $signed({1'b0, ground_level_ff});
   assign half = {1'b0, prod_ff[RECIP_100_SHIFT +: SAMPLE_BITS]} + CLIP_MARGIN;
   assign gain_q = prod_ff[RECIP_50_SHIFT +: 15];
   assign cur = neg_ff ? -$signed({2'b00, gain_q}) : $signed({2'b00, gain_q});
   assign diff = cur - past_ff;
   assign lp_mag = prod_ff[ALPHA_BITS +: 16];
   assign lp_term = neg_ff ? -$signed({1'b0, lp_mag}) : $signed({1'b0, lp_mag});
   assign y = $signed({{2{prev_ff[STATE_BITS-1]}}, prev_ff})
            + $signed({lp_term[16], lp_term});

   always_comb begin
      prod_in       = prod_ff;
      mag_in        = mag_ff;
      neg_in        = neg_ff;
      abs_dx_in     = abs_dx_ff;
      past_in       = past_ff;
      prev_in       = prev_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      sample_out_in = sample_out_ff;
      sat_in        = sat_ff;

      unique case (uword.op)
         OP_LOAD: begin
            if (req_valid) begin
               neg_in    = dx[SAMPLE_BITS];
               abs_dx_in = dx[SAMPLE_BITS] ? SAMPLE_BITS'(-dx) : dx[SAMPLE_BITS-1:0];
               past_in   = $signed({prev_ff[STATE_BITS-1], prev_ff})
                         - $signed({5'b00000, ground_level_ff});
            end
         end
         OP_MUL: begin
            prod_in = mul_p;
         end
         OP_CLAMP: begin
            if ({1'b0, abs_dx_ff} > half) begin
               mag_in = {{(MAG_BITS-13){1'b0}}, half};
            end else begin
               mag_in = {{(MAG_BITS-SAMPLE_BITS){1'b0}}, abs_dx_ff};
            end
         end
         OP_DIFF: begin
            neg_in = diff[16];
            mag_in = {{(MAG_BITS-16){1'b0}}, diff[16] ? 16'(-diff) : diff[15:0]};
         end
         OP_FINISH: begin
            if (finish) begin
               rsp_valid_in = 1'b1;
               sat_in       = 1'b0;
               if (y > 18'sd32767) begin
                  prev_in = 16'sh7fff;
                  sat_in  = 1'b1;
               end else if (y < -18'sd32768) begin
                  prev_in = 16'sh8000;
                  sat_in  = 1'b1;
               end else begin
                  prev_in = y[STATE_BITS-1:0];
               end
               if (y > $signed({6'b000000, {SAMPLE_BITS{1'b1}}})) begin
                  sample_out_in = '1;
                  sat_in        = 1'b1;
               end else if (y < 18'sd0) begin
                  sample_out_in = '0;
                  sat_in        = 1'b1;
               end else begin
                  sample_out_in = y[SAMPLE_BITS-1:0];
               end
            end
         end
         default: ;
      endcase
   end

   // -------------------------------------------------------------------------
   // Registers.
   // -------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         clip_percent_ff  <= RESET_CLIP_PERCENT;
         gain_setting_ff  <= RESET_GAIN_SETTING;
         lowpass_alpha_ff <= RESET_LOWPASS_ALPHA;
         ground_level_ff  <= RESET_GROUND_LEVEL;
         pc_ff            <= PC_START;
         prev_ff          <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         clip_percent_ff  <= clip_percent_in;
         gain_setting_ff  <= gain_setting_in;
         lowpass_alpha_ff <= lowpass_alpha_in;
         ground_level_ff  <= ground_level_in;
         pc_ff            <= pc_in;
         prev_ff          <= prev_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff       <= prod_in;
      mag_ff        <= mag_in;
      neg_ff        <= neg_in;
      abs_dx_ff     <= abs_dx_in;
      past_ff       <= past_in;
      sample_out_ff <= sample_out_in;
      sat_ff        <= sat_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_sample_out    = sample_out_ff;
   assign rsp_out_saturated = sat_ff;

   // -------------------------------------------------------------------------
   // Assertions.
   // -------------------------------------------------------------------------
   // A sample transfer always starts the program at its first working step.
   a_load_advances: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (pc_ff == PC_START + 1'b1))
      else $error("sample transfer did not advance the sequencer");

   // A new result only appears from the finishing step.
   a_result_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(pc_ff == PC_FINISH))
      else $error("result valid rose outside the finishing step");

   // Any saturation drives the output to one of its rails.
   a_sat_at_rail: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_saturated) |->
         (rsp_sample_out == '0 || rsp_sample_out == '1))
      else $error("saturation flag set with output off the rails");

   // The finishing step never overwrites a result that is still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_sample_out)))
      else $error("waiting result was overwritten");

endmodule

// ----- tb/audio_clip_gain_lowpass_core_test.sv -----
// Self-checking testbench for the clip, gain and one-pole low-pass audio core.
// Depends on acgl_pkg (widths, register indexes, reset values) and on the core itself.
// A scoreboard class predicts each DAC word and checks the results in order.
module audio_clip_gain_lowpass_core_test;
   import acgl_pkg::*;

   // Arithmetic limits of the prediction, derived from the package widths.
   localparam longint UNITY_GAIN  = 50;
   localparam longint STATE_MAX   = (longint'(1) << (STATE_BITS - 1)) - 1;
   localparam longint STATE_MIN   = -(longint'(1) << (STATE_BITS - 1));
   localparam longint SAMPLE_MAX  = (longint'(1) << SAMPLE_BITS) - 1;
   localparam int     PHASE_COUNT = 12;
   localparam int     PHASE_ITEMS = 140;

   // One word the core hands to the DAC.
   typedef struct {
      logic [SAMPLE_BITS-1:0] sample_out;
      logic                   out_saturated;
   } dac_word_type;

   // The scoreboard keeps its own copy of the four registers and of the filter
   // state, predicts one DAC word per sample transfer and checks results in order.
   class lowpass_scoreboard;
      logic [PCT_BITS-1:0]      clip_pct;
      logic [GAIN_BITS-1:0]     gain;
      logic [ALPHA_BITS-1:0]    alpha;
      logic [SAMPLE_BITS-1:0]   ground;
      logic signed [STATE_BITS-1:0] filter_state;
      dac_word_type             expected_outputs[$];
      int                       errors;

      function new();
         clip_pct     = RESET_CLIP_PERCENT;
         gain         = RESET_GAIN_SETTING;
         alpha        = RESET_LOWPASS_ALPHA;
         ground       = RESET_GROUND_LEVEL;
         filter_state = '0;
         errors       = 0;
      endfunction

      function void set_register(csr_index_type idx, logic [CSR_DATA_BITS-1:0] data);
         case (idx)
            CSR_CLIP_PERCENT:  clip_pct = data[PCT_BITS-1:0];
            CSR_GAIN_SETTING:  gain     = data[GAIN_BITS-1:0];
            CSR_LOWPASS_ALPHA: alpha    = data[ALPHA_BITS-1:0];
            CSR_GROUND_LEVEL:  ground   = data[SAMPLE_BITS-1:0];
            default: ;
         endcase
      endfunction

      // Clip about ground, apply gain, then run the one-pole filter. All
      // divisions are on signed values and so truncate toward zero.
      function dac_word_type filter_sample(logic [SAMPLE_BITS-1:0] sample);
         longint       gnd, x, half, cur, past, y, st;
         int           pct;
         dac_word_type r;
         gnd  = longint'(ground);
         x    = longint'(sample);
         // A percentage above full scale behaves as full scale.
         pct  = (clip_pct > PCT_FULL) ? int'(PCT_FULL) : int'(clip_pct);
         half = (longint'(int'(PCT_FULL) - pct) * gnd) / longint'(PCT_FULL)
                + longint'(CLIP_MARGIN);
         // The lower bound may be negative; it is not limited here.
         if (x > gnd + half) x = gnd + half;
         if (x < gnd - half) x = gnd - half;
         cur  = ((x - gnd) * longint'(gain)) / UNITY_GAIN;
         past = longint'(filter_state) - gnd;
         y    = past + (longint'(alpha) * (cur - past)) / (longint'(1) << ALPHA_BITS) + gnd;
         r.out_saturated = 1'b0;
         st = y;
         if (st > STATE_MAX) begin
            st = STATE_MAX;
            r.out_saturated = 1'b1;
         end
         if (st < STATE_MIN) begin
            st = STATE_MIN;
            r.out_saturated = 1'b1;
         end
         filter_state = st[STATE_BITS-1:0];
         if (y > SAMPLE_MAX) begin
            y = SAMPLE_MAX;
            r.out_saturated = 1'b1;
         end
         if (y < 0) begin
            y = 0;
            r.out_saturated = 1'b1;
         end
         r.sample_out = y[SAMPLE_BITS-1:0];
         return r;
      endfunction

      function void note_sample(logic [SAMPLE_BITS-1:0] sample);
         expected_outputs.push_back(filter_sample(sample));
      endfunction

      function void check_output(logic [SAMPLE_BITS-1:0] sample_out, logic out_saturated);
         dac_word_type want;
         if (expected_outputs.size() == 0) begin
            $error("result with nothing pending: sample_out %0d out_saturated %0b",
                   sample_out, out_saturated);
            errors++;
            return;
         end
         want = expected_outputs.pop_front();
         if (sample_out !== want.sample_out) begin
            $error("sample_out: expected %0d, actual %0d", want.sample_out, sample_out);
            errors++;
         end
         if (out_saturated !== want.out_saturated) begin
            $error("out_saturated: expected %0b, actual %0b", want.out_saturated,
                   out_saturated);
            errors++;
         end
      endfunction

      function int pending_count();
         return expected_outputs.size();
      endfunction
   endclass

   // Every input of the core starts at a known value; reset is held high first.
   logic                      clock;
   logic                      reset          = 1'b1;
   logic                      req_valid      = 1'b0;
   logic                      req_ready;
   logic [SAMPLE_BITS-1:0]    req_sample_in  = '0;
   logic                      rsp_valid;
   logic                      rsp_ready      = 1'b0;
   logic [SAMPLE_BITS-1:0]    rsp_sample_out;
   logic                      rsp_out_saturated;
   logic                      csr_we         = 1'b0;
   csr_index_type             csr_index      = CSR_CLIP_PERCENT;
   logic [CSR_DATA_BITS-1:0]  csr_wdata      = '0;

   // When set, neither side inserts idle cycles.
   bit                        steady_traffic = 1'b0;

   lowpass_scoreboard board;

   audio_clip_gain_lowpass_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_sample_in     (req_sample_in),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_sample_out    (rsp_sample_out),
      .rsp_out_saturated (rsp_out_saturated),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Hard limit on the run, well above the length of a correct run.
   initial begin
      #(8 * 400_000);
      $display("Regression FAIL");
      $finish;
   end

   // Result side. Values are read right after the edge, before the core's
   // registers update, so a transfer is seen exactly when valid and ready were
   // both high at that edge. Ready then changes for the next cycle, dropping
   // at random about 19 times in a hundred unless steady traffic is asked for.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         board.check_output(rsp_sample_out, rsp_out_saturated);
      end
      rsp_ready <= steady_traffic || ($urandom_range(99) >= 19);
   end

   // Offers one sample and returns at the edge where its transfer takes place.
   // Sometimes valid drops for a short random pause first. The payload is held until
   // the transfer; valid is not lowered between back-to-back samples.
   task automatic send_sample(input logic [SAMPLE_BITS-1:0] value);
      if (!steady_traffic && $urandom_range(99) < 19) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_sample_in <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_sample(value);
   endtask

   // Stops the sample stream and waits until every predicted word has come
   // back, and then on until the sequencer is back at its first step.
   task automatic wait_until_drained();
      req_valid <= 1'b0;
      while (board.pending_count() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   // Writes all four registers, one per cycle, while the core is idle.
   task automatic load_settings(input logic [CSR_DATA_BITS-1:0] pct, gain_data,
                                input logic [CSR_DATA_BITS-1:0] alpha_value, gnd);
      logic [CSR_DATA_BITS-1:0] values [4];
      values = '{pct, gain_data, alpha_value, gnd};
      for (int i = 0; i < 4; i++) begin
         csr_we    <= 1'b1;
         csr_index <= csr_index_type'(i);
         csr_wdata <= values[i];
         @(posedge clock);
         board.set_register(csr_index_type'(i), values[i]);
      end
      csr_we <= 1'b0;
   endtask

   // Picks a register value: often an extreme, otherwise uniform. Now and then
   // the bits above the register's width carry junk, which the core must drop.
   function automatic logic [CSR_DATA_BITS-1:0] choose_setting(input int unsigned top,
                                                               input int bits);
      logic [CSR_DATA_BITS-1:0] v;
      case ($urandom_range(3))
         0:       v = '0;
         1:       v = CSR_DATA_BITS'(top);
         default: v = CSR_DATA_BITS'($urandom_range(top));
      endcase
      if ($urandom_range(3) == 0) v = v | CSR_DATA_BITS'($urandom << bits);
      return v;
   endfunction

   // Samples: the rails, a window around the current ground level where the
   // clip bounds usually sit, and uniform values.
   function automatic logic [SAMPLE_BITS-1:0] choose_sample();
      int c;
      case ($urandom_range(9))
         0: c = 0;
         1: c = int'(SAMPLE_MAX);
         2, 3, 4: c = int'(board.ground) + int'($urandom_range(1200)) - 600;
         default: c = int'($urandom_range(int'(SAMPLE_MAX)));
      endcase
      if (c < 0) c = 0;
      if (c > int'(SAMPLE_MAX)) c = int'(SAMPLE_MAX);
      return c[SAMPLE_BITS-1:0];
   endfunction

   initial begin
      logic [SAMPLE_BITS-1:0] reset_set [10];
      logic [SAMPLE_BITS-1:0] narrow_set [5];
      logic [SAMPLE_BITS-1:0] zero_gain_set [3];
      logic [SAMPLE_BITS-1:0] low_ground_set [5];

      board = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part. With the reset settings (ground 400, widest window) the
      // window runs from below zero up to 820, so the upper clip edge and both
      // input rails are reached, while the lower bound below zero cannot be.
      reset_set = '{12'd0, 12'd4095, 12'd400, 12'd820, 12'd821,
                    12'd2048, 12'hAAA, 12'h555, 12'd1, 12'd4094};
      foreach (reset_set[i]) send_sample(reset_set[i]);

      // Full percentage, maximum gain and alpha, mid-scale ground: the clip
      // half-width is only the 20-code margin, and the gain scales the clipped distance up.
      wait_until_drained();
      load_settings(CSR_DATA_BITS'(PCT_FULL), 16'd255, 16'd65535, 16'd2048);
      narrow_set = '{12'd2068, 12'd2069, 12'd2027, 12'd0, 12'd4095};
      foreach (narrow_set[i]) send_sample(narrow_set[i]);

      // A percentage above full scale, zero gain, zero alpha and ground at
      // the top code: the filter holds its state whatever the samples are.
      wait_until_drained();
      load_settings(16'd127, 16'd0, 16'd0, 16'd4095);
      zero_gain_set = '{12'd4095, 12'd0, 12'd4074};
      foreach (zero_gain_set[i]) send_sample(zero_gain_set[i]);

      // Ground at zero: the window is just the margin above zero.
      wait_until_drained();
      load_settings(16'd0, 16'd255, 16'd65535, 16'd0);
      low_ground_set = '{12'd0, 12'd20, 12'd21, 12'd4095, 12'd7};
      foreach (low_ground_set[i]) send_sample(low_ground_set[i]);

      // Random phases. Each begins with the core drained, which also makes the
      // sender pause until every predicted word has been checked. One phase
      // runs with no idling on either side.
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         wait_until_drained();
         load_settings(choose_setting(127, PCT_BITS), choose_setting(255, GAIN_BITS),
                       choose_setting(65535, ALPHA_BITS), choose_setting(4095, SAMPLE_BITS));
         steady_traffic = (phase == 3);
         for (int n = 0; n < PHASE_ITEMS; n++) send_sample(choose_sample());
      end
      steady_traffic = 1'b0;

      // Wait for the last words, then on past the core's latency so a
      // stray extra result would still be caught.
      req_valid <= 1'b0;
      while (board.pending_count() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (board.errors == 0 && board.pending_count() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
